FILE: hdl/solar_to_lunar_date_macros.svh
// ----------------------------------------------------------------------------
// solar_to_lunar_date_macros
// Assertion macros shared by the checker.
// ----------------------------------------------------------------------------
`ifndef SOLAR_TO_LUNAR_DATE_MACROS_SVH
`define SOLAR_TO_LUNAR_DATE_MACROS_SVH
// Implication checked every clock, quiet in reset
`define S2L_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("%m: check failed");
// Next-cycle implication
`define S2L_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("%m: check failed");
`endif

FILE: hdl/s2l_pkg.sv
// ----------------------------------------------------------------------------
// s2l_pkg
// Types, year table and helpers for the solar to lunar date converter.
// ----------------------------------------------------------------------------
package s2l_pkg;

    localparam int FIRST_YEAR = 1901;
    localparam int YEAR_COUNT = 199;
    localparam int IDX_W      = $clog2(YEAR_COUNT);

    typedef struct packed {
        logic [11:0] greg_year;
        logic [3:0]  greg_month;
        logic [4:0]  greg_day;
    } in_word_t;

    typedef struct packed {
        logic [11:0] lunar_year;
        logic [3:0]  lunar_month;
        logic [4:0]  lunar_day;
        logic        is_leap_month;
        logic        is_valid;
    } out_word_t;

    localparam logic [23:0] YEAR_ROM [YEAR_COUNT] = '{
        24'h03a953,24'h0752c8,24'h5b253d,24'h0325d0,24'h054dc4,24'h4aab39,24'h02b54d,
        24'h05acc2,24'h2ba936,24'h03a94a,24'h6d92be,24'h0592d2,24'h0525c6,24'h5a55ba,
        24'h0156ce,24'h02b5c3,24'h25b4b7,24'h06d4cb,24'h7ec941,24'h074954,24'h0692c8,
        24'h5d26bc,24'h052b50,24'h015b45,24'h4adab8,24'h036a4d,24'h0754c2,24'h2f4937,
        24'h07494a,24'h66933e,24'h0295d1,24'h052bc6,24'h595b3a,24'h05ad4e,24'h036a44,
        24'h3764b8,24'h03a4cb,24'h7b49bf,24'h0549d3,24'h0295c8,24'h652dbb,24'h0556cf,
        24'h02b545,24'h4daab9,24'h05d24d,24'h05a4c2,24'h2d49b6,24'h054aca,24'h7a96bd,
        24'h029b51,24'h0556c6,24'h5ad53b,24'h02d94e,24'h06d2c3,24'h3ea538,24'h06a54c,
        24'h854abf,24'h054bd2,24'h02ab48,24'h755abc,24'h056acf,24'h036945,24'h4752b9,
        24'h0752cd,24'h032542,24'h364bb5,24'h054dc9,24'h7aad3e,24'h02b551,24'h05b4c6,
        24'h5ba93b,24'h05a94f,24'h0592c3,24'h4b25b7,24'h0525cb,24'h8a55bf,24'h0156d2,
        24'h02b6c7,24'h65b4bc,24'h06d4d0,24'h06c945,24'h4e92b9,24'h0692cd,24'had26c2,
        24'h052b54,24'h015b49,24'h62dabd,24'h036ad1,24'h0754c6,24'h5f493b,24'h07494f,
        24'h069344,24'h352b37,24'h052bca,24'h8a6b3f,24'h01ad53,24'h036ac7,24'h5b64bc,
        24'h03a4d0,24'h0349c5,24'h4a95b8,24'h0295cc,24'h052dc1,24'h2aad36,24'h02b549,
        24'h7daabd,24'h05d252,24'h05a4c7,24'h5d49ba,24'h054ace,24'h0296c3,24'h4556b7,
        24'h055aca,24'h9ad53f,24'h02e953,24'h06d2c8,24'h6ea53c,24'h06a550,24'h064ac5,
        24'h4a9739,24'h02ab4c,24'h055ac1,24'h2ad936,24'h03694a,24'h6752bd,24'h0392d1,
        24'h0325c6,24'h564bba,24'h0655cd,24'h02ad43,24'h356b37,24'h05b4cb,24'hbba93f,
        24'h05a953,24'h0592c8,24'h6d25bc,24'h0525cf,24'h0255c4,24'h52adb8,24'h02d6cc,
        24'h05b541,24'h2da936,24'h06c94a,24'h7e92be,24'h0692d1,24'h052ac6,24'h5a56ba,
        24'h025b4e,24'h02dac2,24'h36d537,24'h0764cb,24'h8f4941,24'h074953,24'h069348,
        24'h652b3c,24'h052bcf,24'h026b44,24'h436ab8,24'h03aacc,24'h03a4c2,24'h3749b5,
        24'h0349c9,24'h7a95bd,24'h0295d1,24'h052dc5,24'h5aad3a,24'h02b54e,24'h05b2c3,
        24'h4ba537,24'h05a54b,24'h8d4abf,24'h054ad3,24'h0296c7,24'h6556bb,24'h055acf,
        24'h02d545,24'h45d2b8,24'h06d2cc,24'h06a542,24'h3e4ab6,24'h064b49,24'h7ca73d,
        24'h02ab51,24'h055ac6,24'h5ad93a,24'h03694e,24'h0752c3,24'h472538,24'h0325ca,
        24'h864bbe,24'h0255d2,24'h02adc7,24'h656b3b,24'h05b54f,24'h03a945,24'h4b92b9,
        24'h0592cc,24'h0545c1,24'h2a4db5
    };

    localparam logic [8:0] FIRST_OF_MONTH [12] = '{
        9'd1, 9'd32, 9'd60, 9'd91, 9'd121, 9'd152,
        9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
    };

    // Gregorian leap rule for years 1900..2099: only 1900 of the centuries
    function automatic logic greg_leap(input logic [11:0] y);
        return (y[1:0] == 2'b00) && (y != 12'd1900);
    endfunction

    // Day of year, month index 0..11
    function automatic logic [9:0] day_of_year(input logic [11:0] y,
                                               input logic [3:0] mi,
                                               input logic [4:0] d);
        logic [9:0] r;
        r = {1'b0, FIRST_OF_MONTH[mi]} + {5'd0, d} - 10'd1;
        if (mi >= 4'd2 && greg_leap(y))
            r = r + 10'd1;
        return r;
    endfunction

endpackage

FILE: hdl/solar_to_lunar_date.sv
// ----------------------------------------------------------------------------
// solar_to_lunar_date
// Gregorian to Chinese lunar date converter driven by a small sequencer.
// ----------------------------------------------------------------------------
// The sequencer steps from idle through the new-year check, a step back to the
// previous lunar year when the date falls before new year, and the month walk
// to output; a rejected word goes straight to output. busy drops as done rises
// and a new word is taken only in idle; one month compared and subtracted per cycle.
// Results are strobed on done for one cycle; the receiver cannot stall.
// Reset (rst_n, asynchronous, active low) returns the sequencer to idle.
module solar_to_lunar_date
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  s2l_pkg::in_word_t  din,
    output logic               busy,
    output logic               done,
    output s2l_pkg::out_word_t dout
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_NY   = 5'b00010,
        ST_PREV = 5'b00100,
        ST_WALK = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [11:0] sy_reg, sy_next, ly_reg, ly_next;
    logic [7:0]  idx_reg, idx_next;
    logic [23:0] word_reg, word_next;
    logic [9:0]  today_reg, today_next;
    logic signed [10:0] lyd_reg, lyd_next;
    logic [3:0]  mon_reg, mon_next;
    logic        valid_reg, valid_next;
    logic        done_next;
    logic        done_reg;
    s2l_pkg::out_word_t dout_reg, dout_next;

    logic [9:0]  ny_day;
    logic [3:0]  leapm, nmon;
    logic [4:0]  mlen;
    logic        in_ok;

    assign leapm = word_reg[23:20];
    assign nmon  = (leapm != 4'd0) ? 4'd13 : 4'd12;
    // Month length bits sit at 7..19, so the bit index needs five bits
    assign mlen  = word_reg[5'd6 + {1'b0, mon_reg}] ? 5'd30 : 5'd29;
    // New-year day of year of the held table word in the current lunar year
    assign ny_day = s2l_pkg::day_of_year(ly_reg, {2'b00, word_reg[6:5]} - 4'd1,
                                         word_reg[4:0]);
    assign in_ok = din.greg_year >= 12'(s2l_pkg::FIRST_YEAR)
        && din.greg_year <= 12'(s2l_pkg::FIRST_YEAR + s2l_pkg::YEAR_COUNT - 1)
        && din.greg_month >= 4'd1 && din.greg_month <= 4'd12
        && din.greg_day != 5'd0;

    always_comb
    begin
        state_next = state_reg;
        sy_next    = sy_reg;
        ly_next    = ly_reg;
        idx_next   = idx_reg;
        word_next  = word_reg;
        today_next = today_reg;
        lyd_next   = lyd_reg;
        mon_next   = mon_reg;
        valid_next = valid_reg;
        dout_next  = dout_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    sy_next    = din.greg_year;
                    ly_next    = din.greg_year;
                    idx_next   = 8'(din.greg_year - 12'(s2l_pkg::FIRST_YEAR));
                    today_next = s2l_pkg::day_of_year(din.greg_year,
                                                      din.greg_month - 4'd1,
                                                      din.greg_day);
                    valid_next = in_ok;
                    state_next = in_ok ? ST_NY : ST_OUT;
                    word_next  = s2l_pkg::YEAR_ROM[8'(din.greg_year
                                 - 12'(s2l_pkg::FIRST_YEAR))];
                end
            end
            ST_NY:
            begin
                // Day within lunar year; step back on or before the eve
                lyd_next = $signed({1'b0, today_reg}) - $signed({1'b0, ny_day}) + 11'sd1;
                if ($signed({1'b0, today_reg}) < $signed({1'b0, ny_day}))
                begin
                    ly_next = sy_reg - 12'd1;
                    if (idx_reg == 8'd0)
                    begin
                        valid_next = 1'b0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 8'd1;
                        word_next  = s2l_pkg::YEAR_ROM[idx_reg - 8'd1];
                        state_next = ST_PREV;
                    end
                end
                else
                begin
                    mon_next   = 4'd1;
                    state_next = ST_WALK;
                end
            end
            ST_PREV:
            begin
                lyd_next = $signed({1'b0, today_reg})
                    + $signed({1'b0, s2l_pkg::day_of_year(ly_reg, 4'd11, 5'd31)})
                    - $signed({1'b0, ny_day}) + 11'sd1;
                mon_next   = 4'd1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                // Advance one month per cycle through the month-length subtractor
                if (mon_reg > nmon)
                begin
                    valid_next = 1'b0;
                    state_next = ST_OUT;
                end
                else if (lyd_reg <= $signed({6'd0, mlen}))
                    state_next = ST_OUT;
                else
                begin
                    lyd_next = lyd_reg - $signed({6'd0, mlen});
                    mon_next = mon_reg + 4'd1;
                end
            end
            ST_OUT:
            begin
                dout_next = '0;
                dout_next.lunar_year = ly_reg;
                if (valid_reg)
                begin
                    dout_next.is_valid  = 1'b1;
                    dout_next.lunar_day = lyd_reg[4:0];
                    if (leapm != 4'd0 && leapm < mon_reg)
                    begin
                        dout_next.lunar_month   = mon_reg - 4'd1;
                        dout_next.is_leap_month = (mon_reg - 4'd1) == leapm;
                    end
                    else
                        dout_next.lunar_month = mon_reg;
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sy_reg    <= sy_next;
        ly_reg    <= ly_next;
        idx_reg   <= idx_next;
        word_reg  <= word_next;
        today_reg <= today_next;
        lyd_reg   <= lyd_next;
        mon_reg   <= mon_next;
        valid_reg <= valid_next;
        dout_reg  <= dout_next;
    end

    assign busy = state_reg != ST_IDLE;
    assign done = done_reg;
    assign dout = dout_reg;

endmodule

FILE: hdl/s2l_checker.sv
// ----------------------------------------------------------------------------
// s2l_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "solar_to_lunar_date_macros.svh"

module s2l_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input s2l_pkg::out_word_t dout
);

    `S2L_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `S2L_ASSERT_NXT(a_done_single, clk, rst_n, done, !done)
    `S2L_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)
    `S2L_ASSERT_IMP(a_invalid_zero, clk, rst_n, done && !dout.is_valid,
                    dout.lunar_month == 4'd0 && dout.lunar_day == 5'd0)
    `S2L_ASSERT_IMP(a_valid_range, clk, rst_n, done && dout.is_valid,
                    dout.lunar_month != 4'd0 && dout.lunar_day != 5'd0)

endmodule

bind solar_to_lunar_date s2l_checker u_s2l_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .dout  (dout)
);
